/* design/lkvc_pkg.sv */
// Shared constants and command types for the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic load_req;
        logic execute;
    } t_cmd;

endpackage

/* design/lkvc_ctrl.sv */
// Controller state machine that sequences request capture, execution and result handoff.
module lkvc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_resp_valid,
    input  logic          i_resp_ready,
    output lkvc_pkg::t_cmd o_cmd
);
    import lkvc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_can_exec;

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_resp_valid = r_out_valid;
    assign w_can_exec   = !r_out_valid || i_resp_ready;

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid;
        o_cmd.load_req  = 1'b0;
        o_cmd.execute   = 1'b0;
        if (r_out_valid && i_resp_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_can_exec) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* design/lkvc_datapath.sv */
// Datapath holding the entry table, recency ranks, occupancy, capacity and result registers.
module lkvc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lkvc_pkg::t_cmd                 i_cmd,
    input  logic                           i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]     i_cfg_data,
    input  logic                           i_req_type,
    input  logic signed [lkvc_pkg::KEY_W-1:0] i_lookup_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] i_write_value,
    output logic                           o_hit,
    output logic signed [lkvc_pkg::VAL_W-1:0] o_read_value
);
    import lkvc_pkg::*;

    localparam int CW = (OCC_W + 1 > CAP_W) ? OCC_W + 1 : CAP_W;

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] n_valid;
    logic [IDX_W-1:0]   r_rank [ENTRIES];
    logic [IDX_W-1:0]   n_rank [ENTRIES];
    logic [KEY_W-1:0]   r_key  [ENTRIES];
    logic [VAL_W-1:0]   r_value[ENTRIES];
    logic [OCC_W-1:0]   r_occ;
    logic [OCC_W-1:0]   n_occ;
    logic [CAP_W-1:0]   r_cap;

    logic               r_req_put;
    logic [KEY_W-1:0]   r_req_key;
    logic [VAL_W-1:0]   r_req_val;

    logic               r_hit;
    logic [VAL_W-1:0]   r_read_value;

    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_evict_vec;
    logic [ENTRIES-1:0] w_valid_after;
    logic               w_hit;
    logic [IDX_W-1:0]   w_found_idx;
    logic [IDX_W-1:0]   w_evict_idx;
    logic [IDX_W-1:0]   w_free_idx;
    logic [IDX_W-1:0]   w_hit_rank;
    logic [IDX_W-1:0]   w_oldest_rank;
    logic [CW-1:0]      w_cap_eff;
    logic [CW-1:0]      w_occ_plus;
    logic               w_over;
    logic               w_evict;
    logic               w_insert;
    logic               w_write_val;
    logic [IDX_W-1:0]   w_write_idx;

    always_comb begin
        w_oldest_rank = IDX_W'(r_occ - OCC_W'(1));
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i]     = r_valid[i] && (r_key[i] == r_req_key);
            w_evict_vec[i] = r_valid[i] && (r_rank[i] == w_oldest_rank);
        end
        w_hit       = |w_match;
        w_found_idx = '0;
        w_evict_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_found_idx = IDX_W'(i);
            end
            if (w_evict_vec[i]) begin
                w_evict_idx = IDX_W'(i);
            end
        end
        w_hit_rank = r_rank[w_found_idx];

        w_cap_eff  = (CW'(r_cap) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(r_cap);
        w_occ_plus = CW'(r_occ) + CW'(1);
        w_over     = w_occ_plus > w_cap_eff;
        w_evict    = r_req_put && !w_hit && w_over && (r_occ != '0);
        w_insert   = r_req_put && !w_hit && !(w_over && (r_occ == '0));

        for (int i = 0; i < ENTRIES; i++) begin
            w_valid_after[i] = r_valid[i] && !(w_evict && (w_evict_idx == IDX_W'(i)));
        end
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!w_valid_after[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end

        n_valid = r_valid;
        n_occ   = r_occ;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (w_hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end
            n_rank[w_found_idx] = '0;
        end else if (w_insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_valid_after[i]) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end else begin
                    n_rank[i] = '0;
                end
            end
            n_valid             = w_valid_after;
            n_valid[w_free_idx] = 1'b1;
            n_occ               = w_evict ? r_occ : r_occ + OCC_W'(1);
        end

        w_write_val = (w_hit && r_req_put) || w_insert;
        w_write_idx = w_hit ? w_found_idx : w_free_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cap   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.execute) begin
                r_valid <= n_valid;
                r_occ   <= n_occ;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_put <= (i_req_type == REQ_PUT);
            r_req_key <= i_lookup_key;
            r_req_val <= i_write_value;
        end
        if (i_cmd.execute) begin
            if (w_write_val) begin
                r_value[w_write_idx] <= r_req_val;
            end
            if (w_insert) begin
                r_key[w_free_idx] <= r_req_key;
            end
            r_hit <= w_hit;
            if (r_req_put) begin
                r_read_value <= '0;
            end else if (w_hit) begin
                r_read_value <= r_value[w_found_idx];
            end else begin
                r_read_value <= '1;
            end
        end
    end

    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;

endmodule

/* design/lru_key_value_cache_top.sv */
// Top level of the fully associative LRU key-value cache.
// Each request passes through two steps: the capture registers take it, then all entries are compared and updated.
// The result register is loaded in the execute step, which waits while an earlier result has not been taken.
// A new request is accepted while an earlier result still waits, but not while one is between capture and execution.
// Reset clears all valid bits, recency ranks and occupancy at once and sets capacity to 16.
module lru_key_value_cache_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]        i_cfg_data,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  logic                              i_req_type,
    input  logic signed [lkvc_pkg::KEY_W-1:0] i_lookup_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] i_write_value,
    output logic                              o_resp_valid,
    input  logic                              i_resp_ready,
    output logic                              o_hit,
    output logic signed [lkvc_pkg::VAL_W-1:0] o_read_value
);
    import lkvc_pkg::*;

    t_cmd w_cmd;

    lkvc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_cmd        (w_cmd)
    );

    lkvc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value)
    );

endmodule

/* test/tb_lru_key_value_cache_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LRU key-value cache: directed and random requests, scoreboard.
module tb_lru_key_value_cache_top;
    import lkvc_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int POOL_SIZE         = 24;
    localparam int PHASES            = 12;
    localparam int PHASE_ITEMS       = 150;
    localparam int LONG_STALL_AT     = 400;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int SETTLE_CYCLES     = 4;

    typedef struct {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cache_req;

    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] value;
    } t_lookup_result;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [CAP_W-1:0]          i_cfg_data    = '0;
    logic                      i_req_valid   = 1'b0;
    logic                      o_req_ready;
    logic                      i_req_type    = REQ_GET;
    logic signed [KEY_W-1:0]   i_lookup_key  = '0;
    logic signed [VAL_W-1:0]   i_write_value = '0;
    logic                      o_resp_valid;
    logic                      i_resp_ready  = 1'b0;
    logic                      o_hit;
    logic signed [VAL_W-1:0]   o_read_value;

    t_cache_req     pending_reqs[$];
    t_lookup_result expected_results[$];
    t_cache_req     offered_req;

    logic             slot_used [ENTRIES];
    logic [KEY_W-1:0] slot_key  [ENTRIES];
    logic [VAL_W-1:0] slot_val  [ENTRIES];
    int unsigned      slot_age  [ENTRIES];
    int unsigned      used_count;
    logic [CAP_W-1:0] capacity_reg;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int phase_cap       [PHASES] = '{1, 31, 5, 0, 16, 3, 17, 8, 2, 12, 16, 4};
    int phase_send_gap  [PHASES] = '{6, 0, 6, 3, 0, 6, 2, 6, 0, 6, 6, 1};
    int phase_recv_gap  [PHASES] = '{6, 0, 3, 6, 0, 6, 6, 2, 6, 0, 6, 1};

    int          send_gap_max    = 3;
    int          recv_gap_max    = 3;
    int          send_wait       = 0;
    int          recv_wait       = 0;
    int          hold_left       = 0;
    int          results_checked = 0;
    int          error_count     = 0;
    int unsigned cycle_count     = 0;

    lru_key_value_cache_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_req_type    (i_req_type),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_resp_valid  (o_resp_valid),
        .i_resp_ready  (i_resp_ready),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_cache_model();
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_age[i]  = 0;
        end
        used_count   = 0;
        capacity_reg = CAP_RESET;
    endfunction

    function automatic void promote_slot(int idx);
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_age[i] < slot_age[idx]) begin
                slot_age[i]++;
            end
        end
        slot_age[idx] = 0;
    endfunction

    function automatic void drop_oldest_slot();
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_age[i] == used_count - 1) begin
                slot_used[i] = 1'b0;
                slot_age[i]  = 0;
                used_count--;
                return;
            end
        end
    endfunction

    function automatic t_lookup_result apply_request(t_cache_req r);
        t_lookup_result res;
        int             found;
        int             eff_cap;
        int             i;
        int             j;
        found   = -1;
        eff_cap = (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
        for (i = 0; i < ENTRIES; i++) begin
            if (found < 0 && slot_used[i] && slot_key[i] == r.key) begin
                found = i;
            end
        end
        if (found >= 0) begin
            if (r.req_type == REQ_PUT) begin
                slot_val[found] = r.value;
            end
            promote_slot(found);
            res.hit   = 1'b1;
            res.value = (r.req_type == REQ_PUT) ? '0 : slot_val[found];
            return res;
        end
        res.hit   = 1'b0;
        res.value = (r.req_type == REQ_PUT) ? '0 : '1;
        if (r.req_type == REQ_GET) begin
            return res;
        end
        if (used_count + 1 > eff_cap) begin
            if (used_count == 0) begin
                return res;
            end
            drop_oldest_slot();
        end
        for (i = 0; i < ENTRIES; i++) begin
            if (!slot_used[i]) begin
                for (j = 0; j < ENTRIES; j++) begin
                    if (slot_used[j]) begin
                        slot_age[j]++;
                    end
                end
                slot_used[i] = 1'b1;
                slot_key[i]  = r.key;
                slot_val[i]  = r.value;
                slot_age[i]  = 0;
                used_count++;
                break;
            end
        end
        return res;
    endfunction

    function automatic void push_request(logic kind, logic [KEY_W-1:0] key,
                                         logic [VAL_W-1:0] value);
        t_cache_req r;
        r.req_type = kind;
        r.key      = key;
        r.value    = value;
        pending_reqs.push_back(r);
    endfunction

    function automatic void push_random_request(int span);
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
        if ($urandom_range(0, 99) < 85) begin
            key = key_pool[$urandom_range(0, span - 1)];
        end else begin
            key = $urandom;
        end
        case ($urandom_range(0, 9))
            0:       value = '1;
            1:       value = 32'h8000_0000;
            2:       value = 32'h7FFF_FFFF;
            3:       value = '0;
            default: value = $urandom;
        endcase
        push_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, key, value);
    endfunction

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_data   <= cap;
        capacity_reg = cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_req_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            if (i_req_valid && o_req_ready) begin
                expected_results.push_back(apply_request(offered_req));
            end
            if (!i_req_valid || o_req_ready) begin
                if (send_wait > 0) begin
                    send_wait   = send_wait - 1;
                    i_req_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    offered_req   = pending_reqs.pop_front();
                    i_req_valid   <= 1'b1;
                    i_req_type    <= offered_req.req_type;
                    i_lookup_key  <= offered_req.key;
                    i_write_value <= offered_req.value;
                    send_wait     = $urandom_range(0, send_gap_max);
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            i_resp_ready <= 1'b0;
        end else begin
            if (o_resp_valid && i_resp_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: hit %0d, read_value %0d", o_hit, o_read_value);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit mismatch: expected %0d, actual %0d", want.hit, o_hit);
                        error_count++;
                    end
                    if (o_read_value !== want.value) begin
                        $error("read_value mismatch: expected %0d, actual %0d",
                               $signed(want.value), o_read_value);
                        error_count++;
                    end
                end
                results_checked++;
                recv_wait = $urandom_range(0, recv_gap_max);
                if (results_checked == LONG_STALL_AT) begin
                    hold_left = LONG_STALL_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left    = hold_left - 1;
                i_resp_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait    = recv_wait - 1;
                i_resp_ready <= 1'b0;
            end else begin
                i_resp_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int p;
        int n;
        int eff_cap;
        int span;
        clear_cache_model();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = '1;
        key_pool[3] = '0;
        for (n = 4; n < POOL_SIZE; n++) begin
            key_pool[n] = $urandom;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With zero capacity and an empty store, a put keeps nothing.
        write_capacity('0);
        push_request(REQ_GET, '0, '0);
        push_request(REQ_PUT, 32'd5, 32'd9);
        push_request(REQ_GET, 32'd5, '0);
        wait_until_drained();

        write_capacity(CAP_W'(16));
        push_request(REQ_GET, 32'h8000_0000, 32'h1234_5678);
        push_request(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        push_request(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        push_request(REQ_PUT, '1, '1);
        push_request(REQ_GET, '1, '0);
        push_request(REQ_GET, 32'h8000_0000, '0);
        push_request(REQ_GET, 32'h7FFF_FFFF, '1);
        push_request(REQ_PUT, 32'h7FFF_FFFF, '0);
        push_request(REQ_GET, 32'h7FFF_FFFF, '0);
        push_request(REQ_PUT, '0, 32'h5A5A_A5A5);
        push_request(REQ_GET, '0, '0);
        push_request(REQ_GET, 32'd12345, '0);
        wait_until_drained();

        for (p = 0; p < PHASES; p++) begin
            write_capacity(CAP_W'(phase_cap[p]));
            send_gap_max = phase_send_gap[p];
            recv_gap_max = phase_recv_gap[p];
            eff_cap      = (phase_cap[p] > ENTRIES) ? ENTRIES : phase_cap[p];
            span         = (eff_cap + 3 > POOL_SIZE) ? POOL_SIZE : eff_cap + 3;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                push_random_request(span);
            end
            wait_until_drained();
        end

        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
